// ===== hw/rtl/adpcm_4bit_decoder_mixer_top_defines.svh =====
// Assertion macros for the 4-bit ADPCM decoder and mixer.
`ifndef ADPCM_4BIT_DECODER_MIXER_TOP_DEFINES_SVH
`define ADPCM_4BIT_DECODER_MIXER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off during reset
`define ADM_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("adm assertion failed");
// Next-cycle implication, sampled on clk, off during reset
`define ADM_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("adm assertion failed");
`else
`define ADM_ASSERT_IMP(lbl, ante, cons)
`define ADM_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== hw/rtl/adm_pkg.sv =====
// Package with payload types, constants and the shift adaptation table.
`timescale 1ns / 1ps
package adm_pkg;

	localparam logic [3:0] SHIFT_MAX   = 4'd12;
	localparam logic [3:0] SHIFT_RESET = 4'd1;
	localparam int         SIGN_BIT    = 3;

	// Configuration register indexes
	localparam logic REG_GAIN       = 1'b0;
	localparam logic REG_MIX_ENABLE = 1'b1;

	typedef struct packed {
		logic [3:0]         code;
		logic signed [31:0] mix_in;
		logic               restart;
		logic               final_in;
	} in_t;

	typedef struct packed {
		logic signed [31:0] sample_out;
		logic               final_out;
	} out_t;

	// Decoded sample on its way to the scaling stage
	typedef struct packed {
		logic [31:0] value;
		logic [31:0] mix_in;
		logic        final_flag;
	} dec_t;

	// Status of the decode stage
	typedef struct packed {
		logic       valid;
		logic [3:0] shift;
	} dec_stat_t;

	// Shift adjustment per magnitude
	function automatic logic signed [2:0] shift_adjust(input logic [2:0] mag);
		logic signed [2:0] adj;
		unique case (mag)
			3'd0: adj = -3'sd1;
			3'd1: adj = 3'sd0;
			3'd2: adj = 3'sd0;
			3'd3: adj = 3'sd1;
			3'd4: adj = 3'sd1;
			3'd5: adj = 3'sd1;
			3'd6: adj = 3'sd2;
			3'd7: adj = 3'sd3;
			default: adj = 3'sd0;
		endcase
		return adj;
	endfunction

endpackage

// ===== hw/rtl/adm_dec.sv =====
// Decode stage: predictor, step shift adaptation and the stage 1 register.
`timescale 1ns / 1ps
module adm_dec (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  take,
	input  logic                  adv,
	input  adm_pkg::in_t          in_data,
	output adm_pkg::dec_t         dec_s1,
	output adm_pkg::dec_stat_t    stat
);

	logic [31:0] prev_q;
	logic [31:0] older_q;
	logic [3:0]  shift_q;
	logic        valid_s1;

	logic [31:0] prev_eff;
	logic [31:0] older_eff;
	logic [3:0]  shift_eff;
	logic [2:0]  mag;
	logic [31:0] step;
	logic [31:0] guess;
	logic [31:0] value;
	logic signed [4:0] ns;
	logic [3:0]  shift_next;

	// Apply restart ahead of this code's decode
	always_comb begin
		if (in_data.restart) begin
			prev_eff  = '0;
			older_eff = '0;
			shift_eff = adm_pkg::SHIFT_RESET;
		end else begin
			prev_eff  = prev_q;
			older_eff = older_q;
			shift_eff = shift_q;
		end
	end

	// Predict by extrapolation and add the signed step
	always_comb begin
		mag   = in_data.code[2:0];
		step  = {29'd0, mag} << shift_eff;
		guess = (prev_eff << 1) - older_eff;
		if (in_data.code[adm_pkg::SIGN_BIT]) begin
			value = guess - step;
		end else begin
			value = guess + step;
		end
	end

	// Adapt the step shift and clamp to 0..SHIFT_MAX
	always_comb begin
		ns = $signed({1'b0, shift_eff}) + 5'(adm_pkg::shift_adjust(mag));
		priority if (ns < 5'sd0) begin
			shift_next = '0;
		end else if (ns > $signed({1'b0, adm_pkg::SHIFT_MAX})) begin
			shift_next = adm_pkg::SHIFT_MAX;
		end else begin
			shift_next = ns[3:0];
		end
	end

	// Advance predictor history on every transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q   <= '0;
			older_q  <= '0;
			shift_q  <= adm_pkg::SHIFT_RESET;
			valid_s1 <= 1'b0;
		end else begin
			if (take) begin
				prev_q   <= value;
				older_q  <= prev_eff;
				shift_q  <= shift_next;
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// Hold the decoded payload for the scaling stage
	always_ff @(posedge clk) begin
		if (take) begin
			dec_s1.value      <= value;
			dec_s1.mix_in     <= in_data.mix_in;
			dec_s1.final_flag <= in_data.final_in;
		end
	end

	assign stat.valid = valid_s1;
	assign stat.shift = shift_q;

endmodule

// ===== hw/rtl/adm_mix.sv =====
// Scale stage: gain multiply, optional mix and the output register.
`timescale 1ns / 1ps
module adm_mix (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           adv,
	input  logic           valid_s1,
	input  adm_pkg::dec_t  dec_s1,
	input  logic [16:0]    gain,
	input  logic           mix_enable,
	output logic           out_valid,
	output adm_pkg::out_t  out_data
);

	logic [31:0] scaled;
	logic [31:0] result;
	logic        valid_s2;
	adm_pkg::out_t data_s2;

	// Scale by gain and, when mix_enable is set, add mix_in, wrapping at 32 bits
	always_comb begin
		scaled = 32'(dec_s1.value * {15'd0, gain});
		if (mix_enable) begin
			result = dec_s1.mix_in + scaled;
		end else begin
			result = scaled;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	// Load the output register when it frees up
	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			data_s2.sample_out <= $signed(result);
			data_s2.final_out  <= dec_s1.final_flag;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = data_s2;

endmodule

// ===== hw/rtl/adpcm_4bit_decoder_mixer_top.sv =====
// Top level of the 4-bit ADPCM decoder with gain and mix.
//
//  channel | signals                       | transfer
//  --------+-------------------------------+-----------------------------
//  input   | in_valid, in_ready, in_data   | in_valid & in_ready
//  output  | out_valid, out_ready, out_data| out_valid & out_ready
//  config  | cfg_we, cfg_index, cfg_data   | cfg_we (no wait, no read-back)
//
// One code per cycle sustained while out_ready holds; an input transfer goes
// through the decode stage (predictor loop closes inside it) and its register,
// then the 32x17 gain multiply and mix add into the output register.
// Reset clears the predictor, sets the step shift to 1, gain to 1, mix off.
// A stalled output holds both stages; in_ready follows out_ready combinationally.
`timescale 1ns / 1ps
`include "adpcm_4bit_decoder_mixer_top_defines.svh"
module adpcm_4bit_decoder_mixer_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  adm_pkg::in_t   in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output adm_pkg::out_t  out_data,
	input  logic           cfg_we,
	input  logic           cfg_index,
	input  logic [16:0]    cfg_data
);

	logic [16:0] gain_q;
	logic        mix_enable_q;
	logic        adv;
	logic        take;
	adm_pkg::dec_t     dec_s1;
	adm_pkg::dec_stat_t stat;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q       <= 17'd1;
			mix_enable_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				adm_pkg::REG_GAIN:       gain_q       <= cfg_data;
				adm_pkg::REG_MIX_ENABLE: mix_enable_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Pipeline advances when the output register is free or drained
	assign adv      = !out_valid || out_ready;
	assign in_ready = !stat.valid || adv;
	assign take     = in_valid && in_ready;

	adm_dec u_dec (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.adv     (adv),
		.in_data (in_data),
		.dec_s1  (dec_s1),
		.stat    (stat)
	);

	adm_mix u_mix (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.valid_s1   (stat.valid),
		.dec_s1     (dec_s1),
		.gain       (gain_q),
		.mix_enable (mix_enable_q),
		.out_valid  (out_valid),
		.out_data   (out_data)
	);

	`ADM_ASSERT_NXT(a_take_fills_s1, take, stat.valid)
	`ADM_ASSERT_NXT(a_s1_holds_on_stall, stat.valid && !adv, stat.valid && $stable(dec_s1))
	`ADM_ASSERT_IMP(a_ready_when_s1_empty, !stat.valid, in_ready)
	`ADM_ASSERT_IMP(a_shift_in_range, 1'b1, stat.shift <= adm_pkg::SHIFT_MAX)

endmodule
